>>> hw/rtl/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// q2e_pkg: shared types and constants for the quaternion to Euler converter
// Fixed formats, square root sizing, CORDIC angle table and lane bundles.
// ---------------------------------------------------------------------------
package q2e_pkg;

  localparam int Q_W      = 16;  // quaternion component width, Q2.14
  localparam int AW       = 16;  // angle width, Q3.12
  localparam int THR_W    = 12;  // lock threshold width
  localparam int OPW      = 36;  // CORDIC x/y operand width
  localparam int ZW       = 20;  // CORDIC Q16 angle accumulator width
  localparam int PW       = 32;  // component product width, Q28
  localparam int S_W      = 30;  // clamped asin argument, +-2^28
  localparam int SQ_IN_W  = 57;  // s*s, at most 2^56
  localparam int RAD_W    = 58;  // radicand padded to an even width
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = 34;
  localparam int ATAN_LEN = 24;

  localparam logic signed [OPW-1:0] ONE_Q28     = OPW'(64'sd268435456);
  localparam logic [RAD_W-1:0]      ONE_Q56     = RAD_W'(1) << 56;
  localparam logic signed [ZW-1:0]  HALF_PI_Q16 = ZW'(32'sd102944);
  localparam logic signed [17:0]    HALF_PI_Q12 = 18'sd6434;
  localparam logic signed [AW-1:0]  PI_Q12      = 16'sd12868;

  // Operands produced by the product/sum front end
  typedef struct packed {
    logic signed [S_W-1:0] s;
    logic                  clamped;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] lk_y;
    logic signed [OPW-1:0] lk_x;
  } q2e_args_t;

  // One finished result
  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic                 lock;
    logic                 clamped;
  } q2e_result_t;

  // round(atan(2^-i) * 65536)
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:  val = ZW'(32'sd51472);
      1:  val = ZW'(32'sd30386);
      2:  val = ZW'(32'sd16055);
      3:  val = ZW'(32'sd8150);
      4:  val = ZW'(32'sd4091);
      5:  val = ZW'(32'sd2047);
      6:  val = ZW'(32'sd1024);
      7:  val = ZW'(32'sd512);
      8:  val = ZW'(32'sd256);
      9:  val = ZW'(32'sd128);
      10: val = ZW'(32'sd64);
      11: val = ZW'(32'sd32);
      12: val = ZW'(32'sd16);
      13: val = ZW'(32'sd8);
      14: val = ZW'(32'sd4);
      15: val = ZW'(32'sd2);
      16: val = ZW'(32'sd1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/q2e_prod.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// q2e_prod: component products and sums
// Stage one forms the ten pairwise products, stage two the atan2 operands
// and the saturated asin argument.
// ---------------------------------------------------------------------------
module q2e_prod
  import q2e_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [Q_W-1:0] qx,
  input  wire logic signed [Q_W-1:0] qy,
  input  wire logic signed [Q_W-1:0] qz,
  input  wire logic signed [Q_W-1:0] qw,
  output q2e_args_t                  args
);

  logic signed [PW-1:0] pxx, pyy, pzz, pww, pwy, pxz, pxy, pwz, pwx, pyz;
  logic signed [OPW-1:0] s_full;
  q2e_args_t args_next;

  // Form products
  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= qx * qx;
      pyy <= qy * qy;
      pzz <= qz * qz;
      pww <= qw * qw;
      pwy <= qw * qy;
      pxz <= qx * qz;
      pxy <= qx * qy;
      pwz <= qw * qz;
      pwx <= qw * qx;
      pyz <= qy * qz;
    end
  end

  // Form sums and saturate the asin argument
  always_comb begin
    s_full = (OPW'(pwy) - OPW'(pxz)) <<< 1;
    args_next.clamped = 1'b0;
    if (s_full > ONE_Q28) begin
      args_next.s       = S_W'(ONE_Q28);
      args_next.clamped = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      args_next.s       = S_W'(-ONE_Q28);
      args_next.clamped = 1'b1;
    end else begin
      args_next.s = S_W'(s_full);
    end
    args_next.yaw_y  = (OPW'(pxy) + OPW'(pwz)) <<< 1;
    args_next.yaw_x  = OPW'(pxx) - OPW'(pyy) - OPW'(pzz) + OPW'(pww);
    args_next.roll_y = (OPW'(pwx) + OPW'(pyz)) <<< 1;
    args_next.roll_x = OPW'(pww) - OPW'(pxx) - OPW'(pyy) + OPW'(pzz);
    args_next.lk_y   = (OPW'(pyz) <<< 1) - (OPW'(pwx) <<< 1);
    args_next.lk_x   = (OPW'(pxz) <<< 1) + (OPW'(pwy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      args <= args_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/q2e_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// q2e_isqrt: pipelined floor square root of 2^56 - s*s
// One root bit per stage, restoring digit recurrence.
// ---------------------------------------------------------------------------
module q2e_isqrt
  import q2e_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [SQ_IN_W-1:0] sq,
  output logic      [ROOT_W-1:0]  root
);

  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];
  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];
  logic [RAD_W-1:0]  rad0;

  assign rad0 = ONE_Q56 - RAD_W'(sq);

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_t = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});

    // Decide one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= rad_in << 2;
      end
    end
  end

  assign root = root_q[SQ_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// q2e_cordic: pipelined vectoring CORDIC atan2
// Quadrant pre-rotation stage, then one micro-rotation per stage; the Q16
// angle is rounded to Q12 at the output.
// ---------------------------------------------------------------------------
module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [OPW-1:0] y,
  input  wire logic signed [OPW-1:0] x,
  output logic signed [AW-1:0]       angle
);

  logic signed [OPW-1:0] x0, y0;
  logic signed [ZW-1:0]  z0;
  logic                  zero0;
  logic signed [OPW-1:0] xs [STAGES];
  logic signed [OPW-1:0] ys [STAGES];
  logic signed [ZW-1:0]  zs [STAGES];
  logic                  zero_s [STAGES];
  logic signed [ZW-1:0]  z_round;

  // Pre-rotate the left half plane by +-pi/2
  always_ff @(posedge clk) begin
    if (en) begin
      zero0 <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          x0 <= y;
          y0 <= -x;
          z0 <= HALF_PI_Q16;
        end else begin
          x0 <= -y;
          y0 <= x;
          z0 <= -HALF_PI_Q16;
        end
      end else begin
        x0 <= x;
        y0 <= y;
        z0 <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [OPW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0]  z_in;
    logic                  zero_in;

    if (i == 0) begin : g_first
      assign x_in    = x0;
      assign y_in    = y0;
      assign z_in    = z0;
      assign zero_in = zero0;
    end else begin : g_next
      assign x_in    = xs[i-1];
      assign y_in    = ys[i-1];
      assign z_in    = zs[i-1];
      assign zero_in = zero_s[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    // Rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        zero_s[i] <= zero_in;
        if (y_in >= 0) begin
          xs[i] <= x_in + dx;
          ys[i] <= y_in - dy;
          zs[i] <= z_in + atan_q16(i);
        end else begin
          xs[i] <= x_in - dx;
          ys[i] <= y_in + dy;
          zs[i] <= z_in - atan_q16(i);
        end
      end
    end
  end

  // Round Q16 to Q12
  assign z_round = zs[STAGES-1] + ZW'(8);
  assign angle   = zero_s[STAGES-1] ? '0 : z_round[ZW-1:4];

endmodule
`default_nettype wire

>>> hw/rtl/q2e_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// q2e_delay: stalling shift line
// Holds lane results until the slower lanes catch up.
// ---------------------------------------------------------------------------
module q2e_delay #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Advance the line
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

>>> hw/rtl/quaternion_to_euler.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_to_euler: Q2.14 quaternion to Z-Y-X Euler angles in Q3.12
// Usage:
//   Input channel in_valid/in_ready carries quat_x/y/z/w; output channel
//   out_valid/out_ready carries roll, pitch, yaw and the lock and clamp flags.
//   lock_threshold_we writes lock_threshold_wdata; the user must write it only
//   while the block is idle, which the block does not enforce. One transaction
//   per clock is accepted while in_ready is high. The pipeline is two product/sum
//   stages, one squaring stage, 29 square root stages, CORDIC_STAGES + 1 pitch
//   CORDIC stages, one merge stage and one output register.
//   Roll, yaw and locked-yaw CORDIC lanes run beside the square root and
//   their results wait in a shift line to meet pitch in the merge stage.
//   A two-entry output buffer lets the pipeline run while a result waits;
//   when both entries are full in_ready drops and the whole pipeline holds.
//   Reset empties the pipeline and buffer and sets lock_threshold to 1.
// ---------------------------------------------------------------------------
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    lock_threshold_we,
  input  wire logic [THR_W-1:0]        lock_threshold_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [Q_W-1:0]   quat_x,
  input  wire logic signed [Q_W-1:0]   quat_y,
  input  wire logic signed [Q_W-1:0]   quat_z,
  input  wire logic signed [Q_W-1:0]   quat_w,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [AW-1:0]         roll_angle,
  output logic signed [AW-1:0]         pitch_angle,
  output logic signed [AW-1:0]         yaw_angle,
  output logic                         gimbal_lock,
  output logic                         pitch_clamped
);

  localparam int LAT     = 5 + SQ_STEPS + CORDIC_STAGES;
  localparam int SIDE_D  = 1 + SQ_STEPS;
  localparam int CLAMP_D = 2 + SQ_STEPS + CORDIC_STAGES;

  logic                       en;
  logic [LAT-1:0]             vld;
  logic [THR_W-1:0]           lock_threshold;
  q2e_args_t                  args;
  logic signed [2*S_W-1:0]    s_sq;
  logic [SQ_IN_W-1:0]         sq;
  logic [ROOT_W-1:0]          root;
  logic [S_W-1:0]             s_dly;
  logic signed [S_W-1:0]      s_al;
  logic signed [AW-1:0]       pitch_a, yaw_n, roll_n, yaw_l;
  logic [3*AW-1:0]            side_dly;
  logic signed [AW-1:0]       yaw_n_d, roll_n_d, yaw_l_d;
  logic [0:0]                 clamp_d;
  logic signed [AW:0]         mag;
  logic signed [AW+1:0]       gap;
  q2e_result_t                merge_next, merge_q, out_q, skid_q;
  logic                       skid_valid;
  logic                       push;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign push     = en && vld[LAT-1];

  // Hold the lock threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= THR_W'(1);
    end else if (lock_threshold_we) begin
      lock_threshold <= lock_threshold_wdata;
    end
  end

  // Track transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  q2e_prod u_prod (
    .clk (clk),
    .en  (en),
    .qx  (quat_x),
    .qy  (quat_y),
    .qz  (quat_z),
    .qw  (quat_w),
    .args(args)
  );

  // Square the asin argument
  assign s_sq = args.s * args.s;
  always_ff @(posedge clk) begin
    if (en) begin
      sq <= s_sq[SQ_IN_W-1:0];
    end
  end

  q2e_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .sq  (sq),
    .root(root)
  );

  q2e_delay #(.WIDTH(S_W), .DEPTH(SIDE_D)) u_s_dly (
    .clk (clk),
    .en  (en),
    .din (args.s),
    .dout(s_dly)
  );
  assign s_al = s_dly;

  // Pitch lane
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk  (clk),
    .en   (en),
    .y    (OPW'(s_al)),
    .x    (OPW'({1'b0, root})),
    .angle(pitch_a)
  );

  // Yaw, roll and locked-yaw lanes
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk  (clk),
    .en   (en),
    .y    (args.yaw_y),
    .x    (args.yaw_x),
    .angle(yaw_n)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk  (clk),
    .en   (en),
    .y    (args.roll_y),
    .x    (args.roll_x),
    .angle(roll_n)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_lock_yaw (
    .clk  (clk),
    .en   (en),
    .y    (args.lk_y),
    .x    (args.lk_x),
    .angle(yaw_l)
  );

  q2e_delay #(.WIDTH(3*AW), .DEPTH(SIDE_D)) u_side_dly (
    .clk (clk),
    .en  (en),
    .din ({yaw_n, roll_n, yaw_l}),
    .dout(side_dly)
  );
  assign {yaw_n_d, roll_n_d, yaw_l_d} = side_dly;

  q2e_delay #(.WIDTH(1), .DEPTH(CLAMP_D)) u_clamp_dly (
    .clk (clk),
    .en  (en),
    .din (args.clamped),
    .dout(clamp_d)
  );

  // Merge lanes: pick the lock or normal branch
  always_comb begin
    mag = (pitch_a < 0) ? -(AW+1)'(pitch_a) : (AW+1)'(pitch_a);
    gap = HALF_PI_Q12 - (AW+2)'(mag);
    merge_next.pitch   = pitch_a;
    merge_next.clamped = clamp_d[0];
    merge_next.lock    = gap <= $signed({{(AW+2-THR_W){1'b0}}, lock_threshold});
    if (merge_next.lock) begin
      merge_next.roll = '0;
      merge_next.yaw  = (pitch_a < 0) ? PI_Q12 - yaw_l_d : yaw_l_d;
    end else begin
      merge_next.roll = roll_n_d;
      merge_next.yaw  = yaw_n_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merge_q <= merge_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_q <= merge_q;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= merge_q;
    end
  end

  assign roll_angle    = out_q.roll;
  assign pitch_angle   = out_q.pitch;
  assign yaw_angle     = out_q.yaw;
  assign gimbal_lock   = out_q.lock;
  assign pitch_clamped = out_q.clamped;

  // Skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled while output was free");

  // Lock branch reports zero roll
  a_lock_roll: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gimbal_lock) |-> (roll_angle == '0))
    else $error("nonzero roll in gimbal lock");

endmodule
`default_nettype wire
